### sv/usb_ep0_control_responder_assert.svh
// Assertion helpers shared by the responder RTL.
`ifndef USB_EP0_CONTROL_RESPONDER_ASSERT_SVH
`define USB_EP0_CONTROL_RESPONDER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define UEP0_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define UEP0_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/uep0_pkg.sv
package uep0_pkg;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_VENDOR_ID  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PRODUCT_ID = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_POWER  = 2'd2;
	localparam int CFG_DATA_W = 16;

	localparam logic [15:0] VENDOR_ID_RST  = 16'h1234;
	localparam logic [15:0] PRODUCT_ID_RST = 16'h5678;
	localparam logic [7:0]  MAX_POWER_RST  = 8'd50;

	// Token codes in int_status[5:4]
	localparam logic [1:0] TOK_OUT   = 2'b00;
	localparam logic [1:0] TOK_IN    = 2'b10;
	localparam logic [1:0] TOK_SETUP = 2'b11;

	localparam logic [7:0] REQ_SET_ADDRESS = 8'h05;
	localparam logic [7:0] REQ_GET_DESC    = 8'h06;

	localparam logic [7:0] DT_DEVICE    = 8'h01;
	localparam logic [7:0] DT_CONFIG    = 8'h02;
	localparam logic [7:0] DT_QUALIFIER = 8'h06;

	localparam logic [7:0] CTL_BUS_RESET   = 8'h02;
	localparam logic [7:0] CTL_DATA_IN     = 8'hC0;
	localparam logic [7:0] CTL_STATUS_ACK  = 8'h40;
	localparam logic [7:0] CTL_IN_TO_STAT  = 8'hC2;
	localparam logic [7:0] CTL_STATUS_DONE = 8'h42;

	localparam int LEN_W = 5;
	localparam int DEV_LEN = 18;
	localparam int CFG_LEN = 9;
	localparam logic [LEN_W-1:0] DEV_LEN_V = LEN_W'(DEV_LEN);
	localparam logic [LEN_W-1:0] CFG_LEN_V = LEN_W'(CFG_LEN);

	localparam logic [LEN_W-1:0] DEV_VID_LO = 5'd8;
	localparam logic [LEN_W-1:0] DEV_VID_HI = 5'd9;
	localparam logic [LEN_W-1:0] DEV_PID_LO = 5'd10;
	localparam logic [LEN_W-1:0] DEV_PID_HI = 5'd11;
	localparam logic [LEN_W-1:0] CFG_PWR    = 5'd8;

	localparam logic [7:0] DEV_ROM [DEV_LEN] = '{
		8'h12, 8'h01, 8'h00, 8'h02, 8'hFF, 8'h00, 8'h00, 8'h40, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01
	};
	localparam logic [7:0] CFG_ROM [CFG_LEN] = '{
		8'h09, 8'h02, 8'h09, 8'h00, 8'h01, 8'h01, 8'h00, 8'hC0, 8'h00
	};

	typedef enum logic [1:0] {
		DESC_NONE,
		DESC_DEV,
		DESC_CFG
	} desc_sel_t;

	// Control state held in the state memory
	typedef struct packed {
		logic [7:0] dev_addr;
		logic [7:0] pend_addr;
		logic       stage;     // 0 data stage, 1 status stage
	} ep0_state_t;

	typedef struct packed {
		logic [7:0] length_low;
		logic [7:0] value_high;
		logic [7:0] value_low;
		logic [7:0] request_code;
		logic [7:0] request_type;
		logic [7:0] int_status;
		logic       kind;
	} in_item_t;

	function automatic logic [7:0] desc_byte(
		input desc_sel_t        sel,
		input logic [LEN_W-1:0] idx,
		input logic [15:0]      vid,
		input logic [15:0]      pid,
		input logic [7:0]       pwr
	);
		logic [7:0] b;
		b = '0;
		case (sel)
			DESC_DEV: begin
				if (idx == DEV_VID_LO) b = vid[7:0];
				else if (idx == DEV_VID_HI) b = vid[15:8];
				else if (idx == DEV_PID_LO) b = pid[7:0];
				else if (idx == DEV_PID_HI) b = pid[15:8];
				else if (idx < DEV_LEN_V) b = DEV_ROM[idx];
			end
			DESC_CFG: begin
				if (idx == CFG_PWR) b = pwr;
				else if (idx < CFG_LEN_V) b = CFG_ROM[idx[3:0]];
			end
			default: b = '0;
		endcase
		return b;
	endfunction

endpackage

### sv/uep0_state_mem.sv
`include "usb_ep0_control_responder_assert.svh"

module uep0_state_mem (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rd_en,
	input  logic                  wr_en,
	input  uep0_pkg::ep0_state_t  wr_data,
	output uep0_pkg::ep0_state_t  rd_data
);

	uep0_pkg::ep0_state_t mem [1];
	uep0_pkg::ep0_state_t rd_data_q;
	logic                 valid_q;

	// An entry never written reads as the reset state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr_en) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[0] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_data_q <= '0;
		end else if (rd_en) begin
			rd_data_q <= valid_q ? mem[0] : '0;
		end
	end

	assign rd_data = rd_data_q;

	`UEP0_ASSERT_NOW(a_no_rw_overlap, clk, arst_n, rd_en, !wr_en, "state read and write overlap")
	`UEP0_ASSERT_NEXT(a_wr_sets_valid, clk, arst_n, wr_en, valid_q, "state entry not marked valid")
	`UEP0_ASSERT_NEXT(a_rd_holds, clk, arst_n, !rd_en, $stable(rd_data_q), "read data moved without read")

endmodule

### sv/usb_ep0_control_responder.sv
// Channel   Dir  Beat contents (low bit first)
// cfg_*     in   register write: index, 16-bit data, no handshake
// s_axis    in   one endpoint 0 event; tuser = kind
// m_axis    out  one result per beat; tlast ends the event's run
//
// Each event runs through accept and state read, then decode and state
// write-back, then 1, 9 or 18 result beats.
// The single-entry state memory is read once and written once per event.
// A stalled beat holds; the next event is taken only after the last beat.
// arst_n resets the control FSM and the state valid bit and reloads the config register defaults.
`include "usb_ep0_control_responder_assert.svh"

module usb_ep0_control_responder (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [uep0_pkg::CFG_IDX_W-1:0]    cfg_addr,
	input  logic [uep0_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// int_status, request_type, request_code, value_low, value_high, length_low
	input  logic [47:0]                       s_axis_tdata,
	// kind
	input  logic [0:0]                        s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// ep0_control, tx_length, current_address, data_byte, 3 zero bits
	output logic [31:0]                       m_axis_tdata,
	// control_written, length_written, data_valid
	output logic [2:0]                        m_axis_tuser,
	output logic                              m_axis_tlast
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_SEND = 3'b100
	} fsm_t;

	fsm_t                  state_q;
	logic [15:0]           vendor_id_q;
	logic [15:0]           product_id_q;
	logic [7:0]            max_power_q;
	uep0_pkg::in_item_t    in_q;
	uep0_pkg::ep0_state_t  st_rd;
	uep0_pkg::ep0_state_t  st_nxt;
	logic                  accept;
	logic                  beat;
	logic                  last_beat;

	logic                         cw_c, lw_c;
	logic [7:0]                   ctl_c;
	logic [uep0_pkg::LEN_W-1:0]   tlen_c;
	uep0_pkg::desc_sel_t          sel_c;

	logic                         cw_q, lw_q, dv_q, m_valid_q;
	logic [7:0]                   ctl_q, addr_q;
	logic [uep0_pkg::LEN_W-1:0]   tlen_q, idx_q;
	uep0_pkg::desc_sel_t          sel_q;

	assign accept = s_axis_tvalid && s_axis_tready;
	assign beat   = m_axis_tvalid && m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vendor_id_q  <= uep0_pkg::VENDOR_ID_RST;
			product_id_q <= uep0_pkg::PRODUCT_ID_RST;
			max_power_q  <= uep0_pkg::MAX_POWER_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				uep0_pkg::CFG_VENDOR_ID:  vendor_id_q  <= cfg_wdata;
				uep0_pkg::CFG_PRODUCT_ID: product_id_q <= cfg_wdata;
				uep0_pkg::CFG_MAX_POWER:  max_power_q  <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			in_q <= uep0_pkg::in_item_t'({s_axis_tdata, s_axis_tuser});
		end
	end

	uep0_state_mem u_state (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.wr_en   (state_q == S_EXEC),
		.wr_data (st_nxt),
		.rd_data (st_rd)
	);

	// Event decode on the state read back from memory
	always_comb begin
		st_nxt = st_rd;
		cw_c   = 1'b0;
		ctl_c  = '0;
		lw_c   = 1'b0;
		tlen_c = '0;
		sel_c  = uep0_pkg::DESC_NONE;
		if (!in_q.kind) begin
			st_nxt.dev_addr  = '0;
			st_nxt.pend_addr = '0;
			cw_c  = 1'b1;
			ctl_c = uep0_pkg::CTL_BUS_RESET;
		end else if (in_q.int_status[3:0] == 4'd0) begin
			case (in_q.int_status[5:4])
				uep0_pkg::TOK_SETUP: begin
					if (in_q.request_type[7]) begin
						if (in_q.request_code == uep0_pkg::REQ_GET_DESC) begin
							case (in_q.value_high)
								uep0_pkg::DT_DEVICE: begin
									st_nxt.stage = 1'b0;
									if (in_q.length_low >= 8'(uep0_pkg::DEV_LEN))
										sel_c = uep0_pkg::DESC_DEV;
								end
								uep0_pkg::DT_CONFIG: begin
									st_nxt.stage = 1'b0;
									if (in_q.length_low >= 8'(uep0_pkg::CFG_LEN))
										sel_c = uep0_pkg::DESC_CFG;
								end
								uep0_pkg::DT_QUALIFIER: begin
									st_nxt.stage = 1'b0;
									lw_c  = 1'b1;
									cw_c  = 1'b1;
									ctl_c = uep0_pkg::CTL_DATA_IN;
								end
								default: ;
							endcase
							if (sel_c != uep0_pkg::DESC_NONE) begin
								lw_c   = 1'b1;
								tlen_c = (sel_c == uep0_pkg::DESC_DEV) ?
									uep0_pkg::DEV_LEN_V : uep0_pkg::CFG_LEN_V;
								cw_c   = 1'b1;
								ctl_c  = uep0_pkg::CTL_DATA_IN;
							end
						end
					end else if (in_q.request_code == uep0_pkg::REQ_SET_ADDRESS) begin
						st_nxt.stage     = 1'b1;
						st_nxt.pend_addr = in_q.value_low;
						lw_c  = 1'b1;
						cw_c  = 1'b1;
						ctl_c = uep0_pkg::CTL_STATUS_ACK;
					end
				end
				uep0_pkg::TOK_IN: begin
					cw_c = 1'b1;
					if (!st_rd.stage) begin
						st_nxt.stage = 1'b1;
						ctl_c = uep0_pkg::CTL_IN_TO_STAT;
					end else begin
						// apply the latched address on the status IN
						if (st_rd.pend_addr != 8'd0) begin
							st_nxt.dev_addr  = st_rd.pend_addr;
							st_nxt.pend_addr = '0;
						end
						ctl_c = uep0_pkg::CTL_STATUS_DONE;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EXEC) begin
			cw_q   <= cw_c;
			ctl_q  <= ctl_c;
			lw_q   <= lw_c;
			tlen_q <= tlen_c;
			addr_q <= st_nxt.dev_addr;
			dv_q   <= (sel_c != uep0_pkg::DESC_NONE);
			sel_q  <= sel_c;
		end
	end

	assign last_beat = !dv_q || (idx_q == tlen_q - uep0_pkg::LEN_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			m_valid_q <= 1'b0;
			idx_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) state_q <= S_EXEC;
				end
				S_EXEC: begin
					m_valid_q <= 1'b1;
					idx_q     <= '0;
					state_q   <= S_SEND;
				end
				S_SEND: begin
					if (beat) begin
						if (last_beat) begin
							m_valid_q <= 1'b0;
							state_q   <= S_IDLE;
						end else begin
							// advance to the next descriptor byte
							idx_q <= idx_q + uep0_pkg::LEN_W'(1);
						end
					end
				end
				default: begin
					state_q   <= S_IDLE;
					m_valid_q <= 1'b0;
				end
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tlast  = last_beat;
	assign m_axis_tuser  = {dv_q, lw_q, cw_q};
	assign m_axis_tdata  = {3'b000,
		dv_q ? uep0_pkg::desc_byte(sel_q, idx_q, vendor_id_q, product_id_q, max_power_q)
		     : 8'd0,
		addr_q, tlen_q, ctl_q};

	`UEP0_ASSERT_NOW(a_no_accept_while_out, clk, arst_n, s_axis_tready, !m_axis_tvalid, "input taken during output run")
	`UEP0_ASSERT_NEXT(a_result_follows, clk, arst_n, accept, ##1 m_axis_tvalid, "no result two cycles after accept")
	`UEP0_ASSERT_NEXT(a_last_to_idle, clk, arst_n, beat && m_axis_tlast, s_axis_tready, "not idle after last beat")
	`UEP0_ASSERT_NOW(a_idx_in_run, clk, arst_n, m_axis_tvalid && dv_q, idx_q < tlen_q, "descriptor index past length")

endmodule
